// ----- design/mmalu_pkg.sv -----
// ---------------------------------------------------------------------------
// mmalu_pkg: shared types and constants
// Widths, opcodes, register indexes and the pipeline payload type used by
// the 128-bit Montgomery modular ALU.
// ---------------------------------------------------------------------------
package mmalu_pkg;

    localparam int W       = 128;
    localparam int QW      = 32;
    localparam int NQ      = W / QW;   // 32-bit digits per 128-bit value
    localparam int STAGES  = 16;       // one pipeline cell per digit product

    typedef enum logic [1:0] {
        CMD_MUL = 2'd0,
        CMD_ADD = 2'd1,
        CMD_SUB = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_P_LO = 2'd0,
        REG_P_HI = 2'd1,
        REG_V_LO = 2'd2,
        REG_V_HI = 2'd3
    } reg_idx_t;

    // Payload carried from cell to cell
    typedef struct packed {
        logic           vld;
        logic [1:0]     cmd;
        logic [W-1:0]   a;     // operand a (mul: multiplicand; later s)
        logic [W-1:0]   b;     // operand b
        logic [2*W:0]   acc;   // running sum t, then t + s*p, with carry
        logic [W-1:0]   sacc;  // running low product t*v
    } cell_t;

endpackage

// ----- design/mmalu_cell.sv -----
// ---------------------------------------------------------------------------
// mmalu_cell: one multiply-accumulate cell
// Adds one 32x32 digit product into the item's accumulators. The phase
// (a*b, t*v, s*p) and digit pair are fixed by the cell's position.
// ---------------------------------------------------------------------------
module mmalu_cell #(
    parameter int PHASE = 0,   // 0: t=a*b  1: s=t*v  2: t+s*p
    parameter int IDX   = 0    // digit pair index within the phase
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic [mmalu_pkg::W-1:0]             mod_p,
    input  logic [mmalu_pkg::W-1:0]             neg_v,
    input  mmalu_pkg::cell_t                    din,
    output mmalu_pkg::cell_t                    dout
);
    localparam int I = IDX / mmalu_pkg::NQ;
    localparam int J = IDX % mmalu_pkg::NQ;

    mmalu_pkg::cell_t                   dout_reg, dout_next;
    logic [mmalu_pkg::QW-1:0]           x, y;
    logic [2*mmalu_pkg::QW-1:0]         prod;
    logic                               is_mul;

    // digit product for this position
    always_comb begin
        is_mul = din.cmd == mmalu_pkg::CMD_MUL;
        case (PHASE)
            0: begin
                x = din.a[I*mmalu_pkg::QW +: mmalu_pkg::QW];
                y = din.b[J*mmalu_pkg::QW +: mmalu_pkg::QW];
            end
            1: begin
                x = din.acc[I*mmalu_pkg::QW +: mmalu_pkg::QW];
                y = neg_v[J*mmalu_pkg::QW +: mmalu_pkg::QW];
            end
            default: begin
                x = din.a[I*mmalu_pkg::QW +: mmalu_pkg::QW];
                y = mod_p[J*mmalu_pkg::QW +: mmalu_pkg::QW];
            end
        endcase
        prod = (2*mmalu_pkg::QW)'(x) * (2*mmalu_pkg::QW)'(y);
        dout_next = din;
        if (is_mul) begin
            case (PHASE)
                0: dout_next.acc = din.acc + ((2*mmalu_pkg::W+1)'(prod)
                                   << ((I + J) * mmalu_pkg::QW));
                1: begin
                    if (I + J < mmalu_pkg::NQ)
                        dout_next.sacc = din.sacc + (mmalu_pkg::W'(prod)
                                         << ((I + J) * mmalu_pkg::QW));
                    // last cell of the phase hands s on in place of a
                    if (IDX == mmalu_pkg::STAGES - 1)
                        dout_next.a = dout_next.sacc;
                end
                default: dout_next.acc = din.acc + ((2*mmalu_pkg::W+1)'(prod)
                                         << ((I + J) * mmalu_pkg::QW));
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg.vld <= 1'b0;
        end else if (en) begin
            dout_reg.vld <= din.vld;
        end
        if (en) begin
            dout_reg.cmd  <= din.cmd;
            dout_reg.a    <= dout_next.a;
            dout_reg.b    <= dout_next.b;
            dout_reg.acc  <= dout_next.acc;
            dout_reg.sacc <= dout_next.sacc;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- design/mmalu_final.sv -----
// ---------------------------------------------------------------------------
// mmalu_final: result stage
// Add/subtract or Montgomery output, then conditional reduction, all registered together.
// ---------------------------------------------------------------------------
module mmalu_final (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic [mmalu_pkg::W-1:0]             mod_p,
    input  mmalu_pkg::cell_t                    din,
    output logic                                vld,
    output logic [mmalu_pkg::W-1:0]             res
);
    logic                       vld_reg;
    logic [mmalu_pkg::W-1:0]    res_reg, res_next;
    logic [mmalu_pkg::W:0]      sum, diff, u;
    logic [mmalu_pkg::W-1:0]    tmp;

    always_comb begin
        sum  = {1'b0, din.a} + {1'b0, din.b};
        diff = {1'b0, din.a} - {1'b0, din.b};
        u    = din.acc[2*mmalu_pkg::W:mmalu_pkg::W];
        case (din.cmd)
            mmalu_pkg::CMD_MUL: begin
                res_next = (u[mmalu_pkg::W] || u[mmalu_pkg::W-1:0] >= mod_p)
                         ? u[mmalu_pkg::W-1:0] - mod_p : u[mmalu_pkg::W-1:0];
            end
            mmalu_pkg::CMD_ADD: begin
                res_next = (sum[mmalu_pkg::W] || sum[mmalu_pkg::W-1:0] >= mod_p)
                         ? sum[mmalu_pkg::W-1:0] - mod_p : sum[mmalu_pkg::W-1:0];
            end
            mmalu_pkg::CMD_SUB: begin
                tmp = diff[mmalu_pkg::W-1:0];
                res_next = diff[mmalu_pkg::W] ? tmp + mod_p : tmp;
            end
            default: res_next = '0;
        endcase
        if (din.cmd != mmalu_pkg::CMD_SUB) tmp = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= din.vld;
        end
        if (en) res_reg <= res_next;
    end

    assign vld = vld_reg;
    assign res = res_reg;

endmodule

// ----- design/montgomery_modular_alu_128_core.sv -----
// ---------------------------------------------------------------------------
// montgomery_modular_alu_128_core: 128-bit modular ALU, top level
// Montgomery multiply, modular add and subtract over configured p.
//
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid/s_tready         tdata: cmd, a_lo, a_hi, b_lo, b_hi
// m_        out  m_tvalid/m_tready         tdata: result_lo, result_hi
// cfg_      in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; a chain of 48 digit-product
// cells (16 each for a*b, t*v, s*p) plus one result stage.
// The whole chain advances when the output register is empty or drained;
// a stalled m_tready holds every cell. Reset clears valid bits and loads
// p = 1 and v = all ones.
// ---------------------------------------------------------------------------
module montgomery_modular_alu_128_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [263:0]    s_tdata,  // cmd[1:0], a_lo, a_hi, b_lo, b_hi, pad
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [127:0]    m_tdata,  // result_low, result_high
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [63:0]     cfg_data
);
    localparam int NC = 3 * mmalu_pkg::STAGES;

    logic [mmalu_pkg::W-1:0]    p_reg, v_reg;
    mmalu_pkg::cell_t           chain [NC+1];
    mmalu_pkg::cell_t           head;
    logic                       en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= mmalu_pkg::W'(1);
            v_reg <= '1;
        end else if (cfg_valid) begin
            case (cfg_index)
                mmalu_pkg::REG_P_LO: p_reg[63:0]   <= cfg_data;
                mmalu_pkg::REG_P_HI: p_reg[127:64] <= cfg_data;
                mmalu_pkg::REG_V_LO: v_reg[63:0]   <= cfg_data;
                mmalu_pkg::REG_V_HI: v_reg[127:64] <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // chain advances unless the result register is full and stalled
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        head.vld  = s_tvalid;
        head.cmd  = s_tdata[1:0];
        head.a    = {s_tdata[129:66], s_tdata[65:2]};
        head.b    = {s_tdata[257:194], s_tdata[193:130]};
        head.acc  = '0;
        head.sacc = '0;
    end
    assign chain[0] = head;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        mmalu_cell #(
            .PHASE(k / mmalu_pkg::STAGES),
            .IDX  (k % mmalu_pkg::STAGES)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (en),
            .mod_p  (p_reg),
            .neg_v  (v_reg),
            .din    (chain[k]),
            .dout   (chain[k+1])
        );
    end

    mmalu_final u_final (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .mod_p  (p_reg),
        .din    (chain[NC]),
        .vld    (m_tvalid),
        .res    (m_tdata)
    );

endmodule

// ----- test/montgomery_modular_alu_128_core_test.sv -----
// ---------------------------------------------------------------------------
// montgomery_modular_alu_128_core_test: self-checking bench for the modular ALU
// Drives requests with bursty gaps, stalls the result side on its own pattern,
// predicts every result in software at 128/256-bit width and compares in order.
// Several moduli are loaded between phases, including the reset and extreme ones.
// ---------------------------------------------------------------------------
module montgomery_modular_alu_128_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 49;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 930;

    // Result store and comparison
    class residue_scoreboard;
        logic [127:0] pending[$];
        int errors;
        int checked;

        function void note_request(logic [127:0] val);
            pending.push_back(val);
        endfunction

        function void check_result(logic [127:0] got);
            logic [127:0] want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected hi %h lo %h, got hi %h lo %h",
                             want[127:64], want[63:0], got[127:64], got[63:0]);
            end
        endfunction
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [263:0]   s_tdata;   // cmd, a_lo, a_hi, b_lo, b_hi, pad
    logic           m_tvalid;
    logic           m_tready;
    logic [127:0]   m_tdata;   // result_low, result_high
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [63:0]    cfg_data;

    logic [127:0] modulus;
    logic [127:0] neg_inv;
    residue_scoreboard sb;
    int cycles;
    bit stall_on;

    montgomery_modular_alu_128_core uut (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Predicted result of one request
    function automatic logic [127:0] modular_result(mmalu_pkg::cmd_t op,
                                                    logic [127:0] a,
                                                    logic [127:0] b);
        logic [255:0] t;
        logic [127:0] s;
        logic [256:0] acc;
        logic [128:0] sum;
        case (op)
            mmalu_pkg::CMD_MUL: begin
                t   = 256'(a) * 256'(b);
                s   = t[127:0] * neg_inv;
                acc = 257'(t) + 257'(256'(s) * 256'(modulus));
                if (acc[256] || acc[255:128] >= modulus)
                    return acc[255:128] - modulus;
                return acc[255:128];
            end
            mmalu_pkg::CMD_ADD: begin
                sum = 129'(a) + 129'(b);
                if (sum[128] || sum[127:0] >= modulus) return sum[127:0] - modulus;
                return sum[127:0];
            end
            mmalu_pkg::CMD_SUB: begin
                if (a < b) return a - b + modulus;
                return a - b;
            end
            default: return '0;
        endcase
    endfunction

    // Timeout watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check accepted results, stall on own pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
        m_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    task automatic write_reg(mmalu_pkg::reg_idx_t idx, logic [63:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
        case (idx)
            mmalu_pkg::REG_P_LO: modulus[63:0]   = val;
            mmalu_pkg::REG_P_HI: modulus[127:64] = val;
            mmalu_pkg::REG_V_LO: neg_inv[63:0]   = val;
            mmalu_pkg::REG_V_HI: neg_inv[127:64] = val;
            default: ;
        endcase
    endtask

    // -p^-1 mod 2^128 by Newton iteration (p odd)
    function automatic logic [127:0] neg_inverse(logic [127:0] p);
        logic [127:0] x;
        x = p;
        for (int i = 0; i < 7; i++) x = x * (128'd2 - p * x);
        return -x;
    endfunction

    task automatic load_modulus(logic [127:0] p, logic [127:0] v);
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        write_reg(mmalu_pkg::REG_P_LO, p[63:0]);
        write_reg(mmalu_pkg::REG_P_HI, p[127:64]);
        write_reg(mmalu_pkg::REG_V_LO, v[63:0]);
        write_reg(mmalu_pkg::REG_V_HI, v[127:64]);
    endtask

    // Send one request; holds tvalid across back-to-back requests
    task automatic send_request(mmalu_pkg::cmd_t op, logic [127:0] a, logic [127:0] b);
        s_tvalid <= 1;
        s_tdata  <= {6'd0, b[127:64], b[63:0], a[127:64], a[63:0], op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(modular_result(op, a, b));
        @(negedge aclk);
    endtask

    task automatic idle_gap();
        s_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Residue below p most of the time, any value otherwise
    function automatic logic [127:0] rand_operand();
        logic [127:0] x;
        x = rand128();
        case ($urandom_range(0, 9))
            0: return modulus - 1;
            1: return 128'($urandom_range(0, 3));
            2: return x;
            default: return (modulus > 1) ? x % modulus : x;
        endcase
    endfunction

    task automatic random_phase(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                if ($urandom_range(0, 3) != 0) idle_gap();
                burst = $urandom_range(1, 20);
            end
            burst--;
            send_request(mmalu_pkg::cmd_t'($urandom_range(0, 3)), rand_operand(),
                         rand_operand());
        end
        s_tvalid <= 0;
    endtask

    logic [127:0] pr;
    logic [127:0] moduli[5];

    initial begin
        sb        = new();
        cycles    = 0;
        stall_on  = 0;
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        m_tready  = 0;
        cfg_valid = 0;
        cfg_index = mmalu_pkg::REG_P_LO;
        cfg_data  = '0;
        modulus   = 128'd1;
        neg_inv   = '1;
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: reset modulus, then extremes with a large odd modulus
        send_request(mmalu_pkg::CMD_MUL, 128'd0, 128'd0);
        send_request(mmalu_pkg::CMD_ADD, '1, '1);
        send_request(mmalu_pkg::CMD_SUB, 128'd0, '1);
        send_request(mmalu_pkg::CMD_NOP, '1, '1);
        s_tvalid <= 0;
        pr = '1;
        load_modulus(pr, neg_inverse(pr));
        send_request(mmalu_pkg::CMD_MUL, pr - 1, pr - 1);
        send_request(mmalu_pkg::CMD_MUL, '1, '1);            // operands not below p
        send_request(mmalu_pkg::CMD_MUL, 128'd1, 128'd1);
        send_request(mmalu_pkg::CMD_ADD, pr - 1, pr - 1);
        send_request(mmalu_pkg::CMD_ADD, pr - 1, 128'd1);    // sum equals p
        send_request(mmalu_pkg::CMD_ADD, '1, '1);
        send_request(mmalu_pkg::CMD_SUB, 128'd0, pr - 1);
        send_request(mmalu_pkg::CMD_SUB, pr - 1, pr - 1);
        send_request(mmalu_pkg::CMD_SUB, 128'd5, 128'd7);
        send_request(mmalu_pkg::CMD_NOP, rand128(), rand128());
        s_tvalid <= 0;
        // Even modulus with a wrong inverse: arithmetic still as specified
        load_modulus({64'h8000_0000_0000_0000, 64'h0000_0000_0000_0002}, rand128());
        send_request(mmalu_pkg::CMD_MUL, rand128(), rand128());
        send_request(mmalu_pkg::CMD_ADD, rand128(), rand128());
        send_request(mmalu_pkg::CMD_SUB, rand128(), rand128());
        s_tvalid <= 0;

        // Random phases over several odd moduli
        moduli[0] = 128'd3;
        moduli[1] = {64'd0, 64'hffff_ffff_ffff_ffc5};
        moduli[2] = {64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};
        moduli[3] = rand128() | 128'd1;
        moduli[4] = '1;
        for (int k = 0; k < 5; k++) begin
            load_modulus(moduli[k], neg_inverse(moduli[k]));
            random_phase(N_RANDOM / 5);
        end

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        $display("Checked %0d results over reset, directed and five random moduli.",
                 sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
